### rtl/pta_pkg.sv
// Package for the primitive-to-triangle assembly block.
// Holds the triangle and push types and the primitive type codes.
// No dependencies.
package pta_pkg;

  localparam int unsigned IdxW  = 16;
  localparam int unsigned TypeW = 8;
  localparam int unsigned FullLenW = 20;

  localparam logic [TypeW-1:0] TypeList  = 8'd0;
  localparam logic [TypeW-1:0] TypeStrip = 8'd1;
  localparam logic [TypeW-1:0] TypeQuad  = 8'd2;

  typedef struct packed {
    logic [IdxW-1:0] a;
    logic [IdxW-1:0] b;
    logic [IdxW-1:0] c;
    logic            last;
  } tri_t;

  // up to two triangles produced by one index request
  typedef struct packed {
    logic [1:0] n;
    tri_t       t0;
    tri_t       t1;
  } push_t;

endpackage

### rtl/pta_assemble.sv
// Assembly state and triangle forming for one registered index request.
// Depends on pta_pkg.
module pta_assemble #(
  parameter int unsigned LenW = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [pta_pkg::IdxW-1:0]   idx_i,
  input  logic [pta_pkg::TypeW-1:0]  type_i,
  input  logic [LenW-1:0]            len_i,
  input  logic                       first_i,
  input  logic                       in_range_i,
  output pta_pkg::push_t             push_o
);

  logic [2:0][pta_pkg::IdxW-1:0] held_q, held_d;
  logic [1:0] list_q, list_d;
  logic [1:0] quad_q, quad_d;
  logic [1:0] seen_q, seen_d;
  logic       par_q, par_d;

  logic [1:0] list_c, quad_c, seen_c;
  logic       par_c;
  logic       ok;

  always_comb begin
    list_c = first_i ? 2'd0 : list_q;
    quad_c = first_i ? 2'd0 : quad_q;
    seen_c = first_i ? 2'd0 : seen_q;
    par_c  = first_i ? 1'b0 : par_q;
    ok     = in_range_i && (|len_i);

    held_d = held_q;
    list_d = list_c;
    quad_d = quad_c;
    seen_d = seen_c;
    par_d  = par_c;
    push_o = '0;

    if (ok) begin
      unique case (type_i)
        pta_pkg::TypeList: begin
          if (list_c >= 2'd2) begin
            push_o.n  = 2'd1;
            push_o.t0 = '{a: held_q[0], b: held_q[1], c: idx_i, last: 1'b1};
            list_d    = 2'd0;
          end else begin
            held_d[list_c] = idx_i;
            list_d = list_c + 2'd1;
          end
        end
        pta_pkg::TypeStrip: begin
          if (seen_c >= 2'd2) begin
            push_o.n = 2'd1;
            if (par_c) begin
              push_o.t0 = '{a: held_q[0], b: idx_i, c: held_q[1], last: 1'b1};
            end else begin
              push_o.t0 = '{a: held_q[0], b: held_q[1], c: idx_i, last: 1'b1};
            end
            par_d = ~par_c;
          end else begin
            seen_d = seen_c + 2'd1;
          end
          held_d[0] = held_q[1];
          held_d[1] = idx_i;
        end
        pta_pkg::TypeQuad: begin
          if (len_i[1:0] == 2'd0) begin
            if (quad_c >= 2'd3) begin
              push_o.n  = 2'd2;
              push_o.t0 = '{a: held_q[0], b: held_q[1], c: held_q[2], last: 1'b0};
              push_o.t1 = '{a: held_q[0], b: held_q[2], c: idx_i, last: 1'b1};
              quad_d    = 2'd0;
            end else begin
              held_d[quad_c] = idx_i;
              quad_d = quad_c + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      list_q <= '0;
      quad_q <= '0;
      seen_q <= '0;
      par_q  <= 1'b0;
    end else if (en_i) begin
      held_q <= held_d;
      list_q <= list_d;
      quad_q <= quad_d;
      seen_q <= seen_d;
      par_q  <= par_d;
    end
  end

endmodule

### rtl/pta_out_queue.sv
// Two-entry result queue for triangles, registered toward the master side.
// Depends on pta_pkg.
module pta_out_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_en_i,
  input  pta_pkg::push_t push_i,
  input  logic           pop_ready_i,
  output logic           head_valid_o,
  output pta_pkg::tri_t  head_o,
  output logic [1:0]     free_o
);

  pta_pkg::tri_t q0_q, q0_d, q1_q, q1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] base;
  logic [1:0] n;

  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q0_q;
  assign pop          = head_valid_o && pop_ready_i;
  assign base         = cnt_q - {1'b0, pop};
  assign free_o       = 2'd2 - base;
  assign n            = push_en_i ? push_i.n : 2'd0;

  always_comb begin
    q0_d = pop ? q1_q : q0_q;
    q1_d = q1_q;
    unique case (base)
      2'd0: begin
        if (n != 2'd0) q0_d = push_i.t0;
        if (n == 2'd2) q1_d = push_i.t1;
      end
      2'd1: begin
        if (n != 2'd0) q1_d = push_i.t0;
      end
      default: begin
      end
    endcase
    cnt_d = base + n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

endmodule

### rtl/primitive_to_triangle_assembly.sv
// Primitive-to-triangle assembly, top level.
// Slave side: one vertex index per request, with its primitive tags.
// Master side: one triangle per request, tlast on the final triangle of an index.
// Lists give one triangle per triple, strips one per index from the third on
// with alternating winding, quads two per fourth index; other types, quads whose
// length is not a multiple of four, out-of-range or zero-length primitives give nothing.
// An index is taken into an input register, then assembled into a two-entry
// result queue whose head is presented on the master side.
// Throughput: one index per cycle while the result queue has room for its
// triangles; the master side moves one triangle per cycle, so a quad's fourth
// index needs two triangle transfers.
// Reset clears the assembly counters, held indices and both stages.
// When the master stalls the queue fills, the input register holds its index
// and s_axis_tready falls; nothing is dropped.
// Depends on pta_pkg, pta_assemble, pta_out_queue.
module primitive_to_triangle_assembly #(
  parameter int unsigned LENGTH_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // index_value[15:0], prim_length[35:16], zero
  input  logic [9:0]  s_axis_tuser,  // prim_type[7:0], prim_first[8], prim_in_range[9]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // corner_a[15:0], corner_b[31:16], corner_c[47:32]
  output logic        m_axis_tlast   // last_of_item
);

  localparam int unsigned LenW =
    (LENGTH_BITS < pta_pkg::FullLenW) ? LENGTH_BITS : pta_pkg::FullLenW;

  logic                        vld_q;
  logic [pta_pkg::IdxW-1:0]    idx_q;
  logic [pta_pkg::TypeW-1:0]   type_q;
  logic [LenW-1:0]             len_q;
  logic                        first_q;
  logic                        rng_q;

  pta_pkg::push_t push;
  pta_pkg::tri_t  head;
  logic [1:0]     free;
  logic           fire;
  logic           take;

  assign fire          = vld_q && (push.n <= free);
  assign s_axis_tready = !vld_q || fire;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (fire) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q   <= s_axis_tdata[pta_pkg::IdxW-1:0];
      len_q   <= s_axis_tdata[pta_pkg::IdxW +: LenW];
      type_q  <= s_axis_tuser[pta_pkg::TypeW-1:0];
      first_q <= s_axis_tuser[8];
      rng_q   <= s_axis_tuser[9];
    end
  end

  pta_assemble #(
    .LenW(LenW)
  ) u_assemble (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (fire),
    .idx_i      (idx_q),
    .type_i     (type_q),
    .len_i      (len_q),
    .first_i    (first_q),
    .in_range_i (rng_q),
    .push_o     (push)
  );

  pta_out_queue u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_en_i    (fire),
    .push_i       (push),
    .pop_ready_i  (m_axis_tready),
    .head_valid_o (m_axis_tvalid),
    .head_o       (head),
    .free_o       (free)
  );

  assign m_axis_tdata = {head.c, head.b, head.a};
  assign m_axis_tlast = head.last;

endmodule

### bench/pta_checker.sv
// Checker for primitive_to_triangle_assembly: watches both stream channels,
// predicts the triangles of every accepted index and compares them in order.
// Depends on pta_pkg.
module pta_checker #(
  parameter int unsigned LenBits = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // index_value[15:0], prim_length[35:16], zero
  input  logic [9:0]  s_axis_tuser,  // prim_type[7:0], prim_first[8], prim_in_range[9]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,  // corner_a[15:0], corner_b[31:16], corner_c[47:32]
  input  logic        m_axis_tlast,  // last_of_item
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdxW     = pta_pkg::IdxW;
  localparam int unsigned TypeW    = pta_pkg::TypeW;
  localparam int unsigned FullLenW = pta_pkg::FullLenW;

  logic [IdxW-1:0] held [3];
  logic [1:0]      list_phase;
  logic [1:0]      quad_phase;
  logic [1:0]      strip_seen;
  logic            strip_odd;
  pta_pkg::tri_t   tri_q [$];
  pta_pkg::tri_t   got_tri;
  pta_pkg::tri_t   want_tri;
  int              fails;

  function automatic void push_tri(input logic [IdxW-1:0] a, input logic [IdxW-1:0] b,
                                   input logic [IdxW-1:0] c, input logic last);
    pta_pkg::tri_t t;
    t.a    = a;
    t.b    = b;
    t.c    = c;
    t.last = last;
    tri_q.insert(tri_q.size(), t);
  endfunction

  task automatic assemble(input logic [IdxW-1:0] idx, input logic [TypeW-1:0] kind,
                          input logic [FullLenW-1:0] len, input logic first,
                          input logic in_range);
    logic [FullLenW-1:0] used_len;
    used_len = len & ((FullLenW'(1) << LenBits) - FullLenW'(1));
    if (first) begin
      list_phase = '0;
      quad_phase = '0;
      strip_seen = '0;
      strip_odd  = 1'b0;
    end
    if (!in_range || used_len == '0) return;
    case (kind)
      pta_pkg::TypeList: begin
        if (list_phase >= 2'd2) begin
          push_tri(held[0], held[1], idx, 1'b1);
          list_phase = '0;
        end else begin
          held[list_phase] = idx;
          list_phase = list_phase + 2'd1;
        end
      end
      pta_pkg::TypeStrip: begin
        if (strip_seen >= 2'd2) begin
          if (strip_odd) push_tri(held[0], idx, held[1], 1'b1);
          else push_tri(held[0], held[1], idx, 1'b1);
          strip_odd = ~strip_odd;
        end else begin
          strip_seen = strip_seen + 2'd1;
        end
        held[0] = held[1];
        held[1] = idx;
      end
      pta_pkg::TypeQuad: begin
        if (used_len[1:0] != 2'b00) return;
        if (quad_phase >= 2'd3) begin
          push_tri(held[0], held[1], held[2], 1'b0);
          push_tri(held[0], held[2], idx, 1'b1);
          quad_phase = '0;
        end else begin
          held[quad_phase] = idx;
          quad_phase = quad_phase + 2'd1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held[0]    = '0;
      held[1]    = '0;
      held[2]    = '0;
      list_phase = '0;
      quad_phase = '0;
      strip_seen = '0;
      strip_odd  = 1'b0;
      tri_q.delete();
      fails      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_tri.a    = m_axis_tdata[15:0];
        got_tri.b    = m_axis_tdata[31:16];
        got_tri.c    = m_axis_tdata[47:32];
        got_tri.last = m_axis_tlast;
        if (tri_q.size() == 0) begin
          $display("%0t: unexpected triangle, expected none, got a=%h b=%h c=%h last=%b",
                   $time, got_tri.a, got_tri.b, got_tri.c, got_tri.last);
          fails++;
        end else begin
          want_tri = tri_q.pop_front();
          if (got_tri.a !== want_tri.a || got_tri.b !== want_tri.b ||
              got_tri.c !== want_tri.c || got_tri.last !== want_tri.last) begin
            $display("%0t: triangle mismatch, expected a=%h b=%h c=%h last=%b,",
                     $time, want_tri.a, want_tri.b, want_tri.c, want_tri.last);
            $display("  got a=%h b=%h c=%h last=%b",
                     got_tri.a, got_tri.b, got_tri.c, got_tri.last);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        assemble(s_axis_tdata[15:0], s_axis_tuser[7:0], s_axis_tdata[35:16],
                 s_axis_tuser[8], s_axis_tuser[9]);
      end
    end
    fail_count_o <= fails;
    pending_o    <= tri_q.size();
  end

endmodule

### bench/tb_top.sv
// Top of the triangle assembly bench: clock, reset, index stimulus with random
// gaps, a stalling triangle sink, watchdog and verdict.
// Depends on pta_pkg, primitive_to_triangle_assembly and pta_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdxW        = pta_pkg::IdxW;
  localparam int unsigned TypeW       = pta_pkg::TypeW;
  localparam int unsigned FullLenW    = pta_pkg::FullLenW;
  localparam int unsigned Items       = 1200;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 8;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [9:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  int          fail_count;
  int          pending;
  bit          steady   = 1'b0;
  bit          hold_req = 1'b0;
  bit          pressured = 1'b0;
  int unsigned counted  = 0;

  always #10 clk_i = ~clk_i;

  primitive_to_triangle_assembly dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  pta_checker tri_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  task automatic put_index(input logic [IdxW-1:0] idx, input logic [TypeW-1:0] kind,
                           input logic [FullLenW-1:0] len, input bit first,
                           input bit in_range);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, len, idx};
    s_axis_tuser  <= {in_range, first, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    counted++;
  endtask

  task automatic put_prim(input logic [TypeW-1:0] kind, input logic [FullLenW-1:0] len,
                          input int unsigned n, input bit in_range, input bit with_first);
    for (int unsigned i = 0; i < n; i++)
      put_index(IdxW'($urandom()), kind, len, with_first && i == 0, in_range);
  endtask

  task automatic put_random_prim();
    int unsigned         pick;
    int unsigned         n;
    logic [TypeW-1:0]    kind;
    logic [FullLenW-1:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      case ($urandom_range(0, 2))
        0: kind = pta_pkg::TypeList;
        1: kind = pta_pkg::TypeStrip;
        default: kind = pta_pkg::TypeQuad;
      endcase
      if (kind == pta_pkg::TypeList) n = 3 * $urandom_range(1, 4);
      else if (kind == pta_pkg::TypeStrip) n = $urandom_range(3, 10);
      else n = 4 * $urandom_range(1, 3);
      // short or overlong primitives now and then
      if ($urandom_range(0, 3) == 0) n = n - 1 + $urandom_range(0, 2);
      len = $urandom_range(0, 1) ? FullLenW'(n) : FullLenW'($urandom_range(1, 20'hFFFFF));
      if (kind == pta_pkg::TypeQuad) begin
        len[1:0] = 2'b00;
        if (len == '0) len = FullLenW'(4);
      end
      put_prim(kind, len, n, 1'b1, 1'b1);
    end else if (pick < 92) begin
      case ($urandom_range(0, 3))
        0: put_prim(TypeW'($urandom_range(3, 255)), FullLenW'($urandom_range(1, 20'hFFFFF)),
                    $urandom_range(1, 4), 1'b1, 1'b1);
        1: put_prim(TypeW'($urandom_range(0, 2)), FullLenW'($urandom_range(1, 20'hFFFFF)),
                    $urandom_range(1, 6), 1'b0, 1'b1);
        2: put_prim(TypeW'($urandom_range(0, 2)), '0, $urandom_range(1, 4), 1'b1, 1'b1);
        default: begin
          len = FullLenW'($urandom());
          if (len[1:0] == 2'b00) len[0] = 1'b1;
          put_prim(pta_pkg::TypeQuad, len, 4, 1'b1, 1'b1);
        end
      endcase
    end else begin
      // noise: every field random, types switching within a primitive
      n = $urandom_range(1, 6);
      repeat (n) begin
        kind = $urandom_range(0, 1) ? TypeW'($urandom_range(0, 2)) : TypeW'($urandom());
        put_index(IdxW'($urandom()), kind, FullLenW'($urandom()),
                  $urandom_range(0, 3) == 0, $urandom_range(0, 4) != 0);
      end
    end
  endtask

  initial begin : sink
    int unsigned gap;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // list continuing from reset without a start flag
    put_index(16'h0000, pta_pkg::TypeList, 20'd3, 1'b0, 1'b1);
    put_index(16'hFFFF, pta_pkg::TypeList, 20'd3, 1'b0, 1'b1);
    put_index(16'h8001, pta_pkg::TypeList, 20'd3, 1'b0, 1'b1);
    put_prim(pta_pkg::TypeStrip, 20'd5, 5, 1'b1, 1'b1);
    put_prim(pta_pkg::TypeQuad, 20'd4, 4, 1'b1, 1'b1);
    put_prim(pta_pkg::TypeQuad, 20'd6, 1, 1'b1, 1'b1);
    // partial list dropped by the next start
    put_prim(pta_pkg::TypeList, 20'hFFFFF, 2, 1'b1, 1'b1);
    put_prim(8'd3, 20'd3, 1, 1'b1, 1'b1);
    put_prim(8'hFF, 20'd3, 1, 1'b1, 1'b1);
    put_prim(pta_pkg::TypeList, 20'd3, 1, 1'b0, 1'b1);
    put_prim(pta_pkg::TypeList, 20'd0, 1, 1'b1, 1'b1);
    // strip switching to list mid-primitive
    put_prim(pta_pkg::TypeStrip, 20'd4, 3, 1'b1, 1'b1);
    put_prim(pta_pkg::TypeList, 20'd4, 1, 1'b1, 1'b0);
    // indices beyond the stated length
    put_prim(pta_pkg::TypeList, 20'd1, 3, 1'b1, 1'b1);

    counted = 0;
    while (counted < Items) begin
      if (!pressured && counted >= Items / 3) begin
        pressured = 1'b1;
        steady    = 1'b1;
        hold_req  = 1'b1;
        put_prim(pta_pkg::TypeQuad, 20'd4, 40, 1'b1, 1'b1);
      end
      if ($urandom_range(0, 19) == 0) steady = ~steady;
      put_random_prim();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
rtl/pta_pkg.sv
rtl/pta_assemble.sv
rtl/pta_out_queue.sv
rtl/primitive_to_triangle_assembly.sv
bench/pta_checker.sv
bench/tb_top.sv
